// ----- sv/upc_a_check_digit_validator_assert.svh -----
// assertion macros for the check digit validator
// clocked on clk_i; UPCCHK_ASSERT is quiet while rst_ni is low
`ifndef UPC_A_CHECK_DIGIT_VALIDATOR_ASSERT_SVH
`define UPC_A_CHECK_DIGIT_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define UPCCHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define UPCCHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define UPCCHK_ASSERT(label, prop, msg)

`define UPCCHK_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- sv/upcchk_pkg.sv -----
`default_nettype none

package upcchk_pkg;

  // character codes
  localparam logic [7:0] DashCode  = 8'd45;
  localparam logic [7:0] ZeroCode  = 8'd48;
  localparam logic [7:0] DigitEnd  = 8'd58;

  // token rules
  localparam logic [3:0] UpcDigits     = 4'd12;
  localparam logic [3:0] CheckPos      = 4'd11;
  localparam logic [3:0] DigitSat      = 4'd13;
  localparam logic [2:0] DashSat       = 3'd4;
  localparam logic [2:0] DashesGrouped = 3'd3;
  localparam logic [3:0] Modulus       = 4'd10;

  // result status codes, in priority order
  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StManyDash  = 3'd1,
    StDashCount = 3'd2,
    StBadChar   = 3'd3,
    StLength    = 3'd4,
    StCheck     = 3'd5
  } upcchk_status_e;

  // per-token accumulator
  typedef struct packed {
    logic [2:0] dash_cnt;
    logic [3:0] digit_cnt;
    logic [3:0] sum_mod10;
    logic       bad_char;
    logic [3:0] check_digit;
  } upcchk_state_t;

  // reduce a value below 40 to its remainder mod 10
  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] r;
    begin
      if (v >= 6'd30) begin
        r = v - 6'd30;
      end else if (v >= 6'd20) begin
        r = v - 6'd20;
      end else if (v >= 6'd10) begin
        r = v - 6'd10;
      end else begin
        r = v;
      end
      return r[3:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/upcchk_if.sv -----
`default_nettype none

// character stream channel
interface upcchk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// result channel
interface upcchk_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [2:0] status;

  modport source (output valid, output valid_res, output status, input ready);
  modport sink   (input valid, input valid_res, input status, output ready);
endinterface

`default_nettype wire

// ----- sv/upc_a_check_digit_validator.sv -----
// UPC-A check digit validator. Characters of a barcode token arrive one per
// transaction on in_i, the final one flagged by is_last; one character is taken
// every cycle unless a stalled result holds a last character. Each character is
// registered, then folded into the dash count, digit count, mod-10 weighted sum
// and check digit as it leaves the input register. On the last character a
// result (valid_res, status) is loaded into the output register and shows on
// out_o; the accumulator clears for the next token at the same time. A stalled
// result holds the next last character in the input register and the input
// stalls behind it; ordinary characters ahead of it keep flowing.
// Status: 0 valid, 1 more than three dashes, 2 dash count not 0 or 3,
// 3 bad character, 4 digit count not 12, 5 wrong check digit.
`default_nettype none

`include "upc_a_check_digit_validator_assert.svh"

module upc_a_check_digit_validator
  import upcchk_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  upcchk_in_if.sink   in_i,
  upcchk_out_if.source out_o
);

  logic           s1_valid_q;
  logic [7:0]     s1_char_q;
  logic           s1_last_q;
  logic           s1_adv;
  logic           out_free;
  logic           out_valid_q;
  logic           out_valid_res_q;
  upcchk_status_e out_status_q;
  upcchk_status_e status_d;
  upcchk_state_t  state_q;
  upcchk_state_t  state_d;
  upcchk_state_t  state_upd;
  logic [3:0]     digit_val;
  logic [5:0]     weighted;

  // handshake
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_char_q <= in_i.char_code;
      s1_last_q <= in_i.is_last;
    end
  end

  // fold one character into the accumulator
  always_comb begin
    state_upd = state_q;
    digit_val = s1_char_q[3:0];
    if (state_q.digit_cnt[0]) begin
      weighted = {2'b00, digit_val};
    end else begin
      weighted = {1'b0, digit_val, 1'b0} + {2'b00, digit_val};
    end
    if (s1_char_q == DashCode) begin
      if (state_q.dash_cnt < DashSat) begin
        state_upd.dash_cnt = state_q.dash_cnt + 3'd1;
      end
    end else if (s1_char_q >= ZeroCode && s1_char_q < DigitEnd) begin
      if (state_q.digit_cnt < CheckPos) begin
        state_upd.sum_mod10 = mod10({2'b00, state_q.sum_mod10} + weighted);
      end else if (state_q.digit_cnt == CheckPos) begin
        state_upd.check_digit = digit_val;
      end
      if (state_q.digit_cnt < DigitSat) begin
        state_upd.digit_cnt = state_q.digit_cnt + 4'd1;
      end
    end else begin
      state_upd.bad_char = 1'b1;
    end
  end

  // clear after the last character of a token
  always_comb begin
    state_d = state_q;
    if (s1_adv) begin
      state_d = s1_last_q ? '0 : state_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // status of the token including the current character
  upcchk_status u_status (
    .state_i  (state_upd),
    .status_o (status_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_status_q    <= status_d;
      out_valid_res_q <= (status_d == StOk);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = out_valid_res_q;
  assign out_o.status    = out_status_q;

  // checks
  `UPCCHK_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q), "result without a last character")
  `UPCCHK_ASSERT(a_clear_after_last, (s1_adv && s1_last_q) |=> (state_q == '0), "accumulator not cleared after token")
  `UPCCHK_ASSERT(a_res_matches_status, out_valid_q |-> (out_valid_res_q == (out_status_q == StOk)), "valid_res disagrees with status")
  `UPCCHK_ASSERT_ALWAYS(a_counts_saturate, (state_q.dash_cnt <= DashSat) && (state_q.digit_cnt <= DigitSat), "counter beyond saturation")

endmodule

`default_nettype wire

// ----- sv/upcchk_status.sv -----
`default_nettype none

module upcchk_status
  import upcchk_pkg::*;
(
  input  upcchk_state_t  state_i,
  output upcchk_status_e status_o
);

  logic [3:0] expect_digit;

  // expected check digit from the weighted remainder
  always_comb begin
    if (state_i.sum_mod10 == 4'd0) begin
      expect_digit = 4'd0;
    end else begin
      expect_digit = Modulus - state_i.sum_mod10;
    end
  end

  // first failing check wins
  always_comb begin
    if (state_i.dash_cnt > DashesGrouped) begin
      status_o = StManyDash;
    end else if (state_i.dash_cnt != 3'd0 && state_i.dash_cnt != DashesGrouped) begin
      status_o = StDashCount;
    end else if (state_i.bad_char) begin
      status_o = StBadChar;
    end else if (state_i.digit_cnt != UpcDigits) begin
      status_o = StLength;
    end else if (expect_digit != state_i.check_digit) begin
      status_o = StCheck;
    end else begin
      status_o = StOk;
    end
  end

endmodule

`default_nettype wire
